// ----- rtl/grma_pkg.sv -----
// ----------------------------------------------------------------------------
// grma_pkg
// Shared widths, types and constants for the greedy row-minimum assignment.
// ----------------------------------------------------------------------------
`default_nettype none

package grma_pkg;

  localparam int MAX_TASKS = 64;
  localparam int TASK_W    = $clog2(MAX_TASKS);
  localparam int COST_W    = 16;
  localparam int CNT_W     = 7;

  // task_count value after reset
  localparam logic [CNT_W-1:0] TASK_COUNT_RST = CNT_W'(MAX_TASKS);

  typedef logic signed [COST_W-1:0] cost_t;
  typedef logic [TASK_W-1:0]        task_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [MAX_TASKS-1:0]     mask_t;

  // effective N minus one: zero acts as one, anything above MAX_TASKS saturates
  function automatic task_t last_index(input cnt_t cnt);
    task_t res;
    if (cnt == '0) begin
      res = '0;
    end else if (cnt > CNT_W'(MAX_TASKS)) begin
      res = TASK_W'(MAX_TASKS - 1);
    end else begin
      res = TASK_W'(cnt - CNT_W'(1));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/grma_if.sv -----
// ----------------------------------------------------------------------------
// grma channel interfaces
// Valid/ready channels for cost requests and assignment results.
// ----------------------------------------------------------------------------
`default_nettype none

interface grma_in_if;
  import grma_pkg::*;

  logic  valid;
  logic  ready;
  cost_t cost;
  logic  new_matrix;

  modport source (output valid, output cost, output new_matrix, input ready);
  modport sink   (input valid, input cost, input new_matrix, output ready);
endinterface

interface grma_out_if;
  import grma_pkg::*;

  logic  valid;
  logic  ready;
  task_t worker_index;
  task_t assigned_task;
  logic  last_worker;

  modport source (output valid, output worker_index, output assigned_task,
                  output last_worker, input ready);
  modport sink   (input valid, input worker_index, input assigned_task,
                  input last_worker, output ready);
endinterface

`default_nettype wire

// ----- rtl/greedy_row_min_assignment.sv -----
// ----------------------------------------------------------------------------
// greedy_row_min_assignment
// Streams an N by N cost matrix row by row and assigns each worker the
// cheapest task not taken by an earlier worker.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   cost, new_matrix
//  out_chan  out  valid/ready   worker_index, assigned_task, last_worker
//  cfg       in   cfg_wr_en     cfg_wr_data (task_count)
//
//  one cost request per cycle unless stalled; input register, then one compare
//  and mask test into the result register, which takes a row's result at its last cost
//  synchronous active-low reset clears counters, mask and running minimum,
//  task_count returns to MAX_TASKS
//  a stalled result holds the result register; the input stage stalls only when
//  the result register is full and not being taken
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_row_min_assignment (
  input  wire                          clk,
  input  wire                          rst_n,
  grma_in_if.sink                      in_chan,
  grma_out_if.source                   out_chan,
  input  wire                          cfg_wr_en,
  input  wire [grma_pkg::CNT_W-1:0]    cfg_wr_data
);
  import grma_pkg::*;

  cnt_t  task_count_r;

  // input register
  logic  s1_valid_r;
  cost_t s1_cost_r;
  logic  s1_new_r;

  // matrix state
  mask_t used_r,      used_nxt;
  task_t col_r,       col_nxt;
  task_t row_r,       row_nxt;
  cost_t best_cost_r, best_cost_nxt;
  task_t best_task_r, best_task_nxt;
  logic  have_best_r, have_best_nxt;

  // result register
  logic  out_valid_r;
  task_t out_worker_r;
  task_t out_task_r;
  logic  out_last_r;

  logic  s1_go;
  logic  end_row;
  logic  last;
  task_t n_m1;
  task_t chosen;

  // working copies after an optional new-matrix clear
  mask_t used_w;
  task_t col_w, row_w, best_task_w;
  cost_t best_cost_w;
  logic  have_best_w;
  logic  take;

  assign s1_go         = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.worker_index  = out_worker_r;
  assign out_chan.assigned_task = out_task_r;
  assign out_chan.last_worker   = out_last_r;

  assign n_m1 = last_index(task_count_r);

  always_comb begin
    used_w      = s1_new_r ? '0 : used_r;
    col_w       = s1_new_r ? '0 : col_r;
    row_w       = s1_new_r ? '0 : row_r;
    best_cost_w = s1_new_r ? '0 : best_cost_r;
    best_task_w = s1_new_r ? '0 : best_task_r;
    have_best_w = s1_new_r ? 1'b0 : have_best_r;

    take = !used_w[col_w] && (!have_best_w || (s1_cost_r < best_cost_w));
    if (take) begin
      best_cost_w = s1_cost_r;
      best_task_w = col_w;
      have_best_w = 1'b1;
    end

    end_row = (col_w >= n_m1);
    last    = (row_w >= n_m1);
    chosen  = have_best_w ? best_task_w : '0;

    used_nxt      = used_w;
    col_nxt       = col_w + TASK_W'(1);
    row_nxt       = row_w;
    best_cost_nxt = best_cost_w;
    best_task_nxt = best_task_w;
    have_best_nxt = have_best_w;

    if (end_row) begin
      col_nxt       = '0;
      best_cost_nxt = '0;
      best_task_nxt = '0;
      have_best_nxt = 1'b0;
      if (last) begin
        used_nxt = '0;
        row_nxt  = '0;
      end else begin
        if (have_best_w) begin
          used_nxt = used_w | (mask_t'(1) << chosen);
        end
        row_nxt = row_w + TASK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= TASK_COUNT_RST;
    end else if (cfg_wr_en) begin
      task_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_cost_r <= in_chan.cost;
      s1_new_r  <= in_chan.new_matrix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      best_cost_r <= '0;
      best_task_r <= '0;
      have_best_r <= 1'b0;
    end else if (s1_go) begin
      used_r      <= used_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      best_cost_r <= best_cost_nxt;
      best_task_r <= best_task_nxt;
      have_best_r <= have_best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && end_row) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && end_row) begin
      out_worker_r <= row_w;
      out_task_r   <= chosen;
      out_last_r   <= last;
    end
  end

endmodule

`default_nettype wire
